// File: rtl/cct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cct_pkg;

   // scan modes
   localparam logic [2:0] ModeIdle    = 3'd0;
   localparam logic [2:0] ModeToken   = 3'd1;
   localparam logic [2:0] ModeString  = 3'd2;
   localparam logic [2:0] ModeSlash   = 3'd3;
   localparam logic [2:0] ModeComment = 3'd4;

   // token kinds
   localparam logic [3:0] KindNone    = 4'd0;
   localparam logic [3:0] KindLbrace  = 4'd1;
   localparam logic [3:0] KindRbrace  = 4'd2;
   localparam logic [3:0] KindLparen  = 4'd3;
   localparam logic [3:0] KindRparen  = 4'd4;
   localparam logic [3:0] KindInt     = 4'd5;
   localparam logic [3:0] KindFloat   = 4'd6;
   localparam logic [3:0] KindKeyword = 4'd7;
   localparam logic [3:0] KindString  = 4'd8;

   // error codes
   localparam logic [2:0] ErrNone       = 3'd0;
   localparam logic [2:0] ErrInvalid    = 3'd1;
   localparam logic [2:0] ErrComment    = 3'd2;
   localparam logic [2:0] ErrString     = 3'd3;
   localparam logic [2:0] ErrUnfinished = 3'd4;

   // characters
   localparam logic [7:0] ChLbrace  = 8'h7B;
   localparam logic [7:0] ChRbrace  = 8'h7D;
   localparam logic [7:0] ChLparen  = 8'h28;
   localparam logic [7:0] ChRparen  = 8'h29;
   localparam logic [7:0] ChMinus   = 8'h2D;
   localparam logic [7:0] ChDot     = 8'h2E;
   localparam logic [7:0] ChSlash   = 8'h2F;
   localparam logic [7:0] ChNewline = 8'h0A;
   localparam logic [7:0] ChQuote   = 8'h22;
   localparam logic [7:0] ChSpace   = 8'h20;
   localparam logic [7:0] ChTab     = 8'h09;
   localparam logic [7:0] ChReturn  = 8'h0D;

   // result queue geometry
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = 2;
   localparam int QueueCntW  = 3;

   typedef struct packed {
      logic [3:0] token_type;
      logic [7:0] text_byte;
      logic       has_byte;
      logic       token_end;
      logic [2:0] error_code;
      logic       last_of_run;
   } rsp_type;

   // outcome of one byte: up to two results and the next scan state
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
      logic [2:0] mode;
      logic [3:0] kind;
   } step_type;

   // queue status seen by the top level
   typedef struct packed {
      logic                 room;
      logic [QueueCntW-1:0] count;
   } queue_status_type;

   function automatic rsp_type make_rsp(logic [3:0] kind, logic [7:0] text, logic has,
                                        logic fin, logic [2:0] err);
      rsp_type r;
      r.token_type  = kind;
      r.text_byte   = text;
      r.has_byte    = has;
      r.token_end   = fin;
      r.error_code  = err;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == ChSpace || c == ChTab || c == ChReturn || c == ChNewline;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [3:0] bracket_kind(logic [7:0] c);
      logic [3:0] k;
      k = KindNone;
      if (c == ChLbrace) k = KindLbrace;
      if (c == ChRbrace) k = KindRbrace;
      if (c == ChLparen) k = KindLparen;
      if (c == ChRparen) k = KindRparen;
      return k;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cct_if.sv
`timescale 1ns / 1ps
`default_nettype none

// input byte channel
interface cct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// result channel
interface cct_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] token_type;
   logic [7:0] text_byte;
   logic       has_byte;
   logic       token_end;
   logic [2:0] error_code;
   logic       last_of_run;

   modport source (output valid, output token_type, output text_byte, output has_byte,
                   output token_end, output error_code, output last_of_run, input ready);
   modport sink   (input valid, input token_type, input text_byte, input has_byte,
                   input token_end, input error_code, input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/cct_step.sv
`timescale 1ns / 1ps
`default_nettype none

module cct_step (
   input  wire logic [2:0]       mode,
   input  wire logic [3:0]       kind,
   input  wire logic [7:0]       in_byte,
   input  wire logic             end_of_input,
   output cct_pkg::step_type     step
);

   cct_pkg::rsp_type r0;
   cct_pkg::rsp_type r1;
   logic [1:0]       n;
   logic [2:0]       mode_in;
   logic [3:0]       kind_in;
   logic [3:0]       bk;
   cct_pkg::rsp_type byte_rsp;
   cct_pkg::rsp_type close_rsp;
   cct_pkg::rsp_type bracket_rsp;

   assign bk          = cct_pkg::bracket_kind(in_byte);
   assign byte_rsp    = cct_pkg::make_rsp(cct_pkg::KindNone, in_byte, 1'b1, 1'b0,
                                          cct_pkg::ErrNone);
   assign close_rsp   = cct_pkg::make_rsp(kind, 8'd0, 1'b0, 1'b1, cct_pkg::ErrNone);
   assign bracket_rsp = cct_pkg::make_rsp(bk, in_byte, 1'b1, 1'b1, cct_pkg::ErrNone);

   // per-byte decision
   always_comb begin
      r0      = '0;
      r1      = '0;
      n       = 2'd0;
      mode_in = mode;
      kind_in = kind;
      if (end_of_input) begin
         mode_in = cct_pkg::ModeIdle;
         kind_in = cct_pkg::KindNone;
         if (mode == cct_pkg::ModeToken) begin
            r0 = cct_pkg::make_rsp(cct_pkg::KindNone, 8'd0, 1'b0, 1'b0,
                                   cct_pkg::ErrUnfinished);
            n  = 2'd1;
         end else if (mode == cct_pkg::ModeString) begin
            r0 = cct_pkg::make_rsp(cct_pkg::KindNone, 8'd0, 1'b0, 1'b0,
                                   cct_pkg::ErrString);
            n  = 2'd1;
         end else if (mode == cct_pkg::ModeSlash) begin
            r0 = cct_pkg::make_rsp(cct_pkg::KindNone, 8'd0, 1'b0, 1'b0,
                                   cct_pkg::ErrComment);
            n  = 2'd1;
         end
      end else begin
         unique case (mode)
            cct_pkg::ModeToken: begin
               priority if (bk != cct_pkg::KindNone) begin
                  r0      = close_rsp;
                  r1      = bracket_rsp;
                  n       = 2'd2;
                  mode_in = cct_pkg::ModeIdle;
                  kind_in = cct_pkg::KindNone;
               end else if (cct_pkg::is_digit(in_byte)) begin
                  r0 = byte_rsp;
                  n  = 2'd1;
               end else if (in_byte == cct_pkg::ChMinus) begin
                  r0      = cct_pkg::make_rsp(cct_pkg::KindNone, 8'd0, 1'b0, 1'b0,
                                              cct_pkg::ErrInvalid);
                  n       = 2'd1;
                  mode_in = cct_pkg::ModeIdle;
                  kind_in = cct_pkg::KindNone;
               end else if (cct_pkg::is_alpha(in_byte)) begin
                  n = 2'd1;
                  if (kind == cct_pkg::KindKeyword) begin
                     r0 = byte_rsp;
                  end else begin
                     r0      = cct_pkg::make_rsp(cct_pkg::KindNone, 8'd0, 1'b0, 1'b0,
                                                 cct_pkg::ErrInvalid);
                     mode_in = cct_pkg::ModeIdle;
                     kind_in = cct_pkg::KindNone;
                  end
               end else if (in_byte == cct_pkg::ChQuote) begin
                  r0      = close_rsp;
                  n       = 2'd1;
                  mode_in = cct_pkg::ModeString;
                  kind_in = cct_pkg::KindString;
               end else if (in_byte == cct_pkg::ChDot) begin
                  n = 2'd1;
                  if (kind == cct_pkg::KindInt) begin
                     r0      = byte_rsp;
                     kind_in = cct_pkg::KindFloat;
                  end else begin
                     r0      = cct_pkg::make_rsp(cct_pkg::KindNone, 8'd0, 1'b0, 1'b0,
                                                 cct_pkg::ErrInvalid);
                     mode_in = cct_pkg::ModeIdle;
                     kind_in = cct_pkg::KindNone;
                  end
               end else if (in_byte == cct_pkg::ChSlash) begin
                  r0      = close_rsp;
                  n       = 2'd1;
                  mode_in = cct_pkg::ModeSlash;
                  kind_in = cct_pkg::KindNone;
               end else if (cct_pkg::is_space(in_byte)) begin
                  r0      = close_rsp;
                  n       = 2'd1;
                  mode_in = cct_pkg::ModeIdle;
                  kind_in = cct_pkg::KindNone;
               end else begin
                  // other bytes inside a token are dropped
                  n = 2'd0;
               end
            end
            cct_pkg::ModeString: begin
               n = 2'd1;
               if (in_byte == cct_pkg::ChQuote) begin
                  r0      = close_rsp;
                  mode_in = cct_pkg::ModeIdle;
                  kind_in = cct_pkg::KindNone;
               end else begin
                  r0 = byte_rsp;
               end
            end
            cct_pkg::ModeSlash: begin
               if (in_byte == cct_pkg::ChSlash) begin
                  mode_in = cct_pkg::ModeComment;
               end else begin
                  r0      = cct_pkg::make_rsp(cct_pkg::KindNone, 8'd0, 1'b0, 1'b0,
                                              cct_pkg::ErrComment);
                  n       = 2'd1;
                  mode_in = cct_pkg::ModeIdle;
                  kind_in = cct_pkg::KindNone;
               end
            end
            cct_pkg::ModeComment: begin
               if (in_byte == cct_pkg::ChNewline) begin
                  mode_in = cct_pkg::ModeIdle;
               end
            end
            default: begin
               // idle, between tokens
               mode_in = cct_pkg::ModeIdle;
               kind_in = cct_pkg::KindNone;
               priority if (bk != cct_pkg::KindNone) begin
                  r0 = bracket_rsp;
                  n  = 2'd1;
               end else if (cct_pkg::is_digit(in_byte) || in_byte == cct_pkg::ChMinus) begin
                  r0      = byte_rsp;
                  n       = 2'd1;
                  mode_in = cct_pkg::ModeToken;
                  kind_in = cct_pkg::KindInt;
               end else if (cct_pkg::is_alpha(in_byte)) begin
                  r0      = byte_rsp;
                  n       = 2'd1;
                  mode_in = cct_pkg::ModeToken;
                  kind_in = cct_pkg::KindKeyword;
               end else if (in_byte == cct_pkg::ChQuote) begin
                  mode_in = cct_pkg::ModeString;
                  kind_in = cct_pkg::KindString;
               end else if (in_byte == cct_pkg::ChSlash) begin
                  mode_in = cct_pkg::ModeSlash;
               end else if (!cct_pkg::is_space(in_byte)) begin
                  r0 = cct_pkg::make_rsp(cct_pkg::KindNone, 8'd0, 1'b0, 1'b0,
                                         cct_pkg::ErrInvalid);
                  n  = 2'd1;
               end else begin
                  n = 2'd0;
               end
            end
         endcase
      end
      // mark the final result of this byte
      r0.last_of_run = (n == 2'd1);
      r1.last_of_run = 1'b1;
   end

   assign step.count  = n;
   assign step.first  = r0;
   assign step.second = r1;
   assign step.mode   = mode_in;
   assign step.kind   = kind_in;

endmodule

`default_nettype wire

// File: rtl/cct_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cct_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire cct_pkg::step_type       step,
   output cct_pkg::queue_status_type    status,
   cct_rsp_if.source                    rsp_ch
);

   cct_pkg::rsp_type                    q_ff [cct_pkg::QueueDepth];
   logic [cct_pkg::QueuePtrW-1:0]       wr_ptr_ff;
   logic [cct_pkg::QueuePtrW-1:0]       wr_ptr_in;
   logic [cct_pkg::QueuePtrW-1:0]       wr_next;
   logic [cct_pkg::QueuePtrW-1:0]       rd_ptr_ff;
   logic [cct_pkg::QueuePtrW-1:0]       rd_ptr_in;
   logic [cct_pkg::QueueCntW-1:0]       count_ff;
   logic [cct_pkg::QueueCntW-1:0]       count_in;
   logic [1:0]                          push_count;
   logic                                pop;
   cct_pkg::rsp_type                    head;

   // room for a two-result byte
   localparam logic [cct_pkg::QueueCntW-1:0] RoomLimit =
      cct_pkg::QueueCntW'(cct_pkg::QueueDepth - 2);

   assign push_count = push ? step.count : 2'd0;
   assign pop        = rsp_ch.valid && rsp_ch.ready;
   assign wr_next    = wr_ptr_ff + cct_pkg::QueuePtrW'(1);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + cct_pkg::QueuePtrW'(push_count);
      rd_ptr_in = rd_ptr_ff + cct_pkg::QueuePtrW'(pop);
      count_in  = count_ff + cct_pkg::QueueCntW'(push_count)
                  - cct_pkg::QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         q_ff[wr_ptr_ff] <= step.first;
      end
      if (push_count == 2'd2) begin
         q_ff[wr_next] <= step.second;
      end
   end

   assign head                = q_ff[rd_ptr_ff];
   assign rsp_ch.valid        = count_ff != '0;
   assign rsp_ch.token_type   = head.token_type;
   assign rsp_ch.text_byte    = head.text_byte;
   assign rsp_ch.has_byte     = head.has_byte;
   assign rsp_ch.token_end    = head.token_end;
   assign rsp_ch.error_code   = head.error_code;
   assign rsp_ch.last_of_run  = head.last_of_run;

   assign status.room  = count_ff <= RoomLimit;
   assign status.count = count_ff;

endmodule

`default_nettype wire

// File: rtl/config_text_tokenizer.sv
// results: each result is written into the result queue and offered on rsp from there, behind older results
// throughput: one byte per cycle while each byte gives at most one result and rsp
//   keeps up; a byte that gives two results is offered twice on the single rsp port,
//   and the extra result is absorbed by the four-entry result queue
// reset: synchronous, clears the scan state to idle and empties the result queue
`timescale 1ns / 1ps
`default_nettype none

module config_text_tokenizer (
   input  wire logic   clock,
   input  wire logic   reset,
   cct_req_if.sink     req_ch,
   cct_rsp_if.source   rsp_ch
);

   logic [2:0]                  mode_ff;
   logic [2:0]                  mode_in;
   logic [3:0]                  kind_ff;
   logic [3:0]                  kind_in;
   logic                        req_fire;
   cct_pkg::step_type           step;
   cct_pkg::queue_status_type   status;

   assign req_ch.ready = status.room;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // byte decode
   cct_step u_step (
      .mode         (mode_ff),
      .kind         (kind_ff),
      .in_byte      (req_ch.in_byte),
      .end_of_input (req_ch.end_of_input),
      .step         (step)
   );

   // scan state
   assign mode_in = req_fire ? step.mode : mode_ff;
   assign kind_in = req_fire ? step.kind : kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cct_pkg::ModeIdle;
         kind_ff <= cct_pkg::KindNone;
      end else begin
         mode_ff <= mode_in;
         kind_ff <= kind_in;
      end
   end

   // result queue
   cct_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (req_fire),
      .step   (step),
      .status (status),
      .rsp_ch (rsp_ch)
   );

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      status.count <= cct_pkg::QueueCntW'(cct_pkg::QueueDepth))
      else $error("result queue overfilled");

   a_eoi_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_ch.end_of_input |=> mode_ff == cct_pkg::ModeIdle)
      else $error("scan not idle after end of input");

   a_string_kind: assert property (@(posedge clock) disable iff (reset)
      mode_ff == cct_pkg::ModeString |-> kind_ff == cct_pkg::KindString)
      else $error("string mode without string kind");

   a_result_offered: assert property (@(posedge clock) disable iff (reset)
      req_fire && step.count != 2'd0 |=> rsp_ch.valid)
      else $error("pushed result not offered");

endmodule

`default_nettype wire
